// File: sv/arm_data_processing_alu_unit_macros.svh
// Assertion macros used by the checker file of the ALU unit.
`ifndef ARM_DATA_PROCESSING_ALU_UNIT_MACROS_SVH
`define ARM_DATA_PROCESSING_ALU_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ADP_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ADP_ASSERT_ALL(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/adp_alu_pkg.sv
// Types and constants of the data-processing ALU unit.
`default_nettype none

package adp_alu_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned OPCODE_W    = 4;
   localparam int unsigned SHIFT_AMT_W = 8;
   localparam int unsigned CYCLE_W     = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_AND = 4'd0,
      OP_EOR = 4'd1,
      OP_SUB = 4'd2,
      OP_RSB = 4'd3,
      OP_ADD = 4'd4,
      OP_ADC = 4'd5,
      OP_SBC = 4'd6,
      OP_RSC = 4'd7,
      OP_TST = 4'd8,
      OP_TEQ = 4'd9,
      OP_CMP = 4'd10,
      OP_CMN = 4'd11,
      OP_ORR = 4'd12,
      OP_MOV = 4'd13,
      OP_BIC = 4'd14,
      OP_MVN = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_kind_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]    action;
      logic [WORD_W-1:0]      first_operand;
      logic [WORD_W-1:0]      second_operand;
      logic                   operand_is_register;
      logic [1:0]             shift_kind;
      logic [SHIFT_AMT_W-1:0] shift_amount;
      logic                   shift_by_register;
      logic                   set_flags;
      logic                   carry_in;
      logic                   dest_is_pc;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0]  result;
      logic               write_result;
      logic               flag_n;
      logic               flag_z;
      logic               flag_c;
      logic               flag_v;
      logic               update_nzc;
      logic               update_v;
      logic [CYCLE_W-1:0] cycle_count;
      logic               flush_pipeline;
   } rsp_word_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              carry;
   } shift_out_type;

endpackage

`default_nettype wire

// File: sv/adp_alu_ifs.sv
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface adp_alu_req_if
   import adp_alu_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [OPCODE_W-1:0]    action;
   logic [WORD_W-1:0]      first_operand;
   logic [WORD_W-1:0]      second_operand;
   logic                   operand_is_register;
   logic [1:0]             shift_kind;
   logic [SHIFT_AMT_W-1:0] shift_amount;
   logic                   shift_by_register;
   logic                   set_flags;
   logic                   carry_in;
   logic                   dest_is_pc;

   modport source (
      output valid, action, first_operand, second_operand, operand_is_register,
             shift_kind, shift_amount, shift_by_register, set_flags, carry_in,
             dest_is_pc,
      input  ready
   );
   modport sink (
      input  valid, action, first_operand, second_operand, operand_is_register,
             shift_kind, shift_amount, shift_by_register, set_flags, carry_in,
             dest_is_pc,
      output ready
   );
endinterface

interface adp_alu_rsp_if
   import adp_alu_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  result;
   logic               write_result;
   logic               flag_n;
   logic               flag_z;
   logic               flag_c;
   logic               flag_v;
   logic               update_nzc;
   logic               update_v;
   logic [CYCLE_W-1:0] cycle_count;
   logic               flush_pipeline;

   modport source (
      output valid, result, write_result, flag_n, flag_z, flag_c, flag_v,
             update_nzc, update_v, cycle_count, flush_pipeline,
      input  ready
   );
   modport sink (
      input  valid, result, write_result, flag_n, flag_z, flag_c, flag_v,
             update_nzc, update_v, cycle_count, flush_pipeline,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/adp_alu_shifter.sv
// Barrel shifter with register-shift semantics and carry-out.
`default_nettype none

module adp_alu_shifter
   import adp_alu_pkg::*;
(
   input  wire logic [WORD_W-1:0]      value,
   input  wire logic [1:0]             kind,
   input  wire logic [SHIFT_AMT_W-1:0] amount,
   input  wire logic                   carry_in,
   output shift_out_type               shift_out
);

   logic [WORD_W:0]   lsl_ext;
   logic [WORD_W:0]   lsr_ext;
   logic [WORD_W:0]   asr_ext;
   logic [WORD_W-1:0] ror_word;
   logic              over_range;
   logic              is_full_word;

   always_comb begin
      lsl_ext      = {1'b0, value} << amount[4:0];
      lsr_ext      = {value, 1'b0} >> amount[4:0];
      asr_ext      = (WORD_W+1)'($signed({value, 1'b0}) >>> amount[4:0]);
      ror_word     = WORD_W'({value, value} >> amount[4:0]);
      over_range   = (amount[SHIFT_AMT_W-1:5] != '0);
      is_full_word = (amount == SHIFT_AMT_W'(WORD_W));

      shift_out.value = value;
      shift_out.carry = carry_in;
      if (amount != '0) begin
         case (shift_kind_type'(kind))
            SHIFT_LSL: begin
               if (!over_range) begin
                  {shift_out.carry, shift_out.value} = lsl_ext;
               end else begin
                  shift_out.value = '0;
                  shift_out.carry = is_full_word ? value[0] : 1'b0;
               end
            end
            SHIFT_LSR: begin
               if (!over_range) begin
                  {shift_out.value, shift_out.carry} = lsr_ext;
               end else begin
                  shift_out.value = '0;
                  shift_out.carry = is_full_word ? value[WORD_W-1] : 1'b0;
               end
            end
            SHIFT_ASR: begin
               if (!over_range) begin
                  {shift_out.value, shift_out.carry} = asr_ext;
               end else begin
                  shift_out.value = {WORD_W{value[WORD_W-1]}};
                  shift_out.carry = value[WORD_W-1];
               end
            end
            SHIFT_ROR: begin
               // rotate by count mod 32; carry is the new sign bit
               shift_out.value = ror_word;
               shift_out.carry = ror_word[WORD_W-1];
            end
            default: begin
               shift_out.value = value;
               shift_out.carry = carry_in;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: sv/adp_alu_exec.sv
// Operand selection, logic/adder datapath and flag generation.
`default_nettype none

module adp_alu_exec
   import adp_alu_pkg::*;
(
   input  wire req_word_type req_word,
   output rsp_word_type      rsp_word
);

   shift_out_type     shift_out;
   logic [WORD_W-1:0] opnd_a;
   logic [WORD_W-1:0] opnd_b;
   logic              shift_carry;
   logic [WORD_W-1:0] add_x;
   logic [WORD_W-1:0] add_y;
   logic              add_cin;
   logic [WORD_W:0]   add_sum;
   logic [WORD_W-1:0] logic_res;
   logic [WORD_W-1:0] res;
   logic              is_arith;
   logic              is_compare;
   logic              quiet;
   logic              carry_flag;
   logic              ovf_flag;
   logic              pc_write;

   adp_alu_shifter u_shifter (
      .value     (req_word.second_operand),
      .kind      (req_word.shift_kind),
      .amount    (req_word.shift_amount),
      .carry_in  (req_word.carry_in),
      .shift_out (shift_out)
   );

   always_comb begin
      opnd_a      = req_word.first_operand;
      opnd_b      = req_word.operand_is_register ? shift_out.value : req_word.second_operand;
      shift_carry = req_word.operand_is_register ? shift_out.carry : req_word.carry_in;

      add_x      = opnd_a;
      add_y      = ~opnd_b;
      add_cin    = 1'b1;
      is_arith   = 1'b0;
      is_compare = 1'b0;
      logic_res  = '0;
      case (opcode_type'(req_word.action))
         OP_AND: logic_res = opnd_a & opnd_b;
         OP_EOR: logic_res = opnd_a ^ opnd_b;
         OP_SUB: is_arith = 1'b1;
         OP_RSB: begin
            add_x    = opnd_b;
            add_y    = ~opnd_a;
            is_arith = 1'b1;
         end
         OP_ADD: begin
            add_y    = opnd_b;
            add_cin  = 1'b0;
            is_arith = 1'b1;
         end
         OP_ADC: begin
            add_y    = opnd_b;
            add_cin  = req_word.carry_in;
            is_arith = 1'b1;
         end
         OP_SBC: begin
            add_cin  = req_word.carry_in;
            is_arith = 1'b1;
         end
         OP_RSC: begin
            add_x    = opnd_b;
            add_y    = ~opnd_a;
            add_cin  = req_word.carry_in;
            is_arith = 1'b1;
         end
         OP_TST: begin
            logic_res  = opnd_a & opnd_b;
            is_compare = 1'b1;
         end
         OP_TEQ: begin
            logic_res  = opnd_a ^ opnd_b;
            is_compare = 1'b1;
         end
         OP_CMP: begin
            is_arith   = 1'b1;
            is_compare = 1'b1;
         end
         OP_CMN: begin
            add_y      = opnd_b;
            add_cin    = 1'b0;
            is_arith   = 1'b1;
            is_compare = 1'b1;
         end
         OP_ORR: logic_res = opnd_a | opnd_b;
         OP_MOV: logic_res = opnd_b;
         OP_BIC: logic_res = opnd_a & ~opnd_b;
         OP_MVN: logic_res = ~opnd_b;
         default: logic_res = '0;
      endcase

      add_sum    = {1'b0, add_x} + {1'b0, add_y} + (WORD_W+1)'(add_cin);
      res        = is_arith ? add_sum[WORD_W-1:0] : logic_res;
      carry_flag = is_arith ? add_sum[WORD_W] : shift_carry;
      ovf_flag   = is_arith & ((add_x[WORD_W-1] ^ res[WORD_W-1]) &
                               (add_y[WORD_W-1] ^ res[WORD_W-1]));

      // test/compare without S: result and flags zero
      quiet    = is_compare & ~req_word.set_flags;
      pc_write = ~is_compare & req_word.dest_is_pc;

      rsp_word.result         = quiet ? '0 : res;
      rsp_word.write_result   = ~is_compare;
      rsp_word.flag_n         = ~quiet & res[WORD_W-1];
      rsp_word.flag_z         = ~quiet & (res == '0);
      rsp_word.flag_c         = ~quiet & carry_flag;
      rsp_word.flag_v         = ~quiet & ovf_flag;
      rsp_word.update_nzc     = req_word.set_flags;
      rsp_word.update_v       = req_word.set_flags & is_arith;
      rsp_word.cycle_count    = CYCLE_W'(1) + CYCLE_W'(req_word.shift_by_register) +
                                (pc_write ? CYCLE_W'(2) : '0);
      rsp_word.flush_pipeline = pc_write;
   end

endmodule

`default_nettype wire

// File: sv/arm_data_processing_alu_unit.sv
// Top level of the data-processing ALU unit: input register, datapath, result register.
//
//  channel   dir  handshake        contents
//  req_bus   in   valid / ready    opcode, operands, shifter control, S, C, PC dest
//  rsp_bus   out  valid / ready    result, write enable, NZCV, masks, cycles, flush
//
// One word per cycle sustained while rsp_bus is ready; an accepted word passes the input
// register and then the result register before rsp_bus.valid rises.
// The input register and the result register hold one word each, with the shifter
// and adder between them.
// Synchronous reset clears both valid bits; payload registers are not reset.
// A stalled rsp_bus holds its word; req_bus keeps accepting while a stage is free.
`default_nettype none

module arm_data_processing_alu_unit
   import adp_alu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   adp_alu_req_if.sink   req_bus,
   adp_alu_rsp_if.source rsp_bus
);

   req_word_type s1_word_in;
   req_word_type s1_word_ff;
   logic         s1_valid_ff;
   rsp_word_type s2_word_in;
   rsp_word_type s2_word_ff;
   logic         s2_valid_ff;
   logic         s1_ready;
   logic         s2_ready;

   assign s2_ready      = ~s2_valid_ff | rsp_bus.ready;
   assign s1_ready      = ~s1_valid_ff | s2_ready;
   assign req_bus.ready = s1_ready;

   always_comb begin
      s1_word_in.action              = req_bus.action;
      s1_word_in.first_operand       = req_bus.first_operand;
      s1_word_in.second_operand      = req_bus.second_operand;
      s1_word_in.operand_is_register = req_bus.operand_is_register;
      s1_word_in.shift_kind          = req_bus.shift_kind;
      s1_word_in.shift_amount        = req_bus.shift_amount;
      s1_word_in.shift_by_register   = req_bus.shift_by_register;
      s1_word_in.set_flags           = req_bus.set_flags;
      s1_word_in.carry_in            = req_bus.carry_in;
      s1_word_in.dest_is_pc          = req_bus.dest_is_pc;
   end

   adp_alu_exec u_exec (
      .req_word (s1_word_ff),
      .rsp_word (s2_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_bus.valid) begin
         s1_word_ff <= s1_word_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_word_ff <= s2_word_in;
      end
   end

   assign rsp_bus.valid          = s2_valid_ff;
   assign rsp_bus.result         = s2_word_ff.result;
   assign rsp_bus.write_result   = s2_word_ff.write_result;
   assign rsp_bus.flag_n         = s2_word_ff.flag_n;
   assign rsp_bus.flag_z         = s2_word_ff.flag_z;
   assign rsp_bus.flag_c         = s2_word_ff.flag_c;
   assign rsp_bus.flag_v         = s2_word_ff.flag_v;
   assign rsp_bus.update_nzc     = s2_word_ff.update_nzc;
   assign rsp_bus.update_v       = s2_word_ff.update_v;
   assign rsp_bus.cycle_count    = s2_word_ff.cycle_count;
   assign rsp_bus.flush_pipeline = s2_word_ff.flush_pipeline;

endmodule

`default_nettype wire

// File: sv/adp_alu_checker.sv
// Port-level checker for the ALU unit, bound to the top level.
`default_nettype none

`include "arm_data_processing_alu_unit_macros.svh"

module adp_alu_checker
   import adp_alu_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [WORD_W-1:0]  rsp_result,
   input wire logic               rsp_write_result,
   input wire logic               rsp_flag_n,
   input wire logic               rsp_update_nzc,
   input wire logic               rsp_update_v,
   input wire logic [CYCLE_W-1:0] rsp_cycle_count,
   input wire logic               rsp_flush_pipeline
);

   `ADP_ASSERT_ALL(a_idle_after_reset, clock, !reset && $past(reset) |-> !rsp_valid, "word valid right after reset")
   `ADP_ASSERT_RST(a_flush_needs_write, clock, reset, rsp_valid && rsp_flush_pipeline |-> rsp_write_result && (rsp_cycle_count == 3'd3 || rsp_cycle_count == 3'd4), "flush without PC write cost")
   `ADP_ASSERT_RST(a_cycle_range, clock, reset, rsp_valid |-> rsp_cycle_count != 3'd0 && rsp_cycle_count <= 3'd4, "cycle count out of range")
   `ADP_ASSERT_RST(a_v_mask_in_nzc, clock, reset, rsp_valid && rsp_update_v |-> rsp_update_nzc, "V updated without NZC")
   `ADP_ASSERT_RST(a_hold_on_stall, clock, reset, rsp_valid && !rsp_ready && rsp_write_result |=> rsp_valid && $stable(rsp_result) && rsp_flag_n == rsp_result[WORD_W-1], "stalled word changed")

endmodule

bind arm_data_processing_alu_unit adp_alu_checker u_adp_alu_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_result         (rsp_bus.result),
   .rsp_write_result   (rsp_bus.write_result),
   .rsp_flag_n         (rsp_bus.flag_n),
   .rsp_update_nzc     (rsp_bus.update_nzc),
   .rsp_update_v       (rsp_bus.update_v),
   .rsp_cycle_count    (rsp_bus.cycle_count),
   .rsp_flush_pipeline (rsp_bus.flush_pipeline)
);

`default_nettype wire
